### rtl/phong_pkg.sv
// Shared types, constants and arithmetic helpers for the Phong shading pipeline.
// Used by phong_lighting_shader and the testbench; depends on nothing.
package phong_pkg;

    localparam logic [47:0] LIGHT_RESET = 48'h1000_1000_1000;
    localparam logic [31:0] POW_CAP     = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    // floor(y / 10) == (y * RECIP_TEN) >> 22 for all y < 2^17
    localparam logic [18:0] RECIP_TEN   = 19'd419431;
    localparam int          SQRT_STEPS  = 26;
    localparam int          DIV_STEPS   = 32;
    localparam int          POW_STEPS   = 16;

    // Values that ride alongside the specular datapath
    typedef struct packed {
        logic [2:0][15:0] amb;
        logic [2:0][15:0] dif;
        logic [2:0][31:0] iks;
        logic [7:0]       shin;
        logic             spec_on;
    } side_t;

    // Square root stage: radicand consumed two bits per step from the top
    typedef struct packed {
        side_t        side;
        logic [51:0]  x;
        logic [29:0]  rem;
        logic [25:0]  root;
        logic [53:0]  s;
    } sq_t;

    // Divider stage: one quotient bit per step
    typedef struct packed {
        side_t        side;
        logic [25:0]  t;
        logic [25:0]  rem;
        logic [31:0]  sl;
        logic [31:0]  quo;
        logic         ovf;
    } dv_t;

    // Power stage: square or multiply per step
    typedef struct packed {
        side_t        side;
        logic [31:0]  v;
        logic [31:0]  acc;
    } pw_t;

    function automatic logic [15:0] sat16(input logic [31:0] x);
        logic [15:0] r;
        r = (x > 32'd65535) ? 16'hFFFF : x[15:0];
        return r;
    endfunction

    // Q16 multiply with round half up, capped at POW_CAP
    function automatic logic [31:0] mul_q16(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        logic [47:0] rnd;
        logic [31:0] r;
        prod = 64'(a) * 64'(b);
        rnd  = 48'((prod + 64'd32768) >> 16);
        r    = (rnd > 48'(POW_CAP)) ? POW_CAP : rnd[31:0];
        return r;
    endfunction

endpackage

### rtl/phong_lighting_shader.sv
// Phong reflection pipeline: ambient, diffuse and specular RGB terms per sample.
// Depends on phong_pkg (types, constants, rounding and saturation helpers).
//
// A sample is taken on every clock edge where start is high; busy stays low, so a
// new sample may enter every cycle. Each sample's result appears on the result
// ports with done high for one cycle, in order. The pipeline depth is set by the
// specular path: a 26-step square root of the view length, an overflow check and
// a 32-step quotient for V.R, and 16 steps of square-and-multiply for the
// shininess power, each step one pipeline stage. The receiver cannot stall;
// results must be captured in the cycle that done is high.
// light_intensity is written by cfg_we/cfg_data and must only change while no sample
// is in flight.
module phong_lighting_shader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [47:0] cfg_data,
    input  logic [47:0] view_ray_dir,
    input  logic [47:0] surface_normal,
    input  logic [47:0] light_dir,
    input  logic [47:0] ambient_coef,
    input  logic [47:0] diffuse_coef,
    input  logic [47:0] specular_coef,
    input  logic [7:0]  shininess,
    output logic        done,
    output logic [15:0] ambient_red,
    output logic [15:0] ambient_green,
    output logic [15:0] ambient_blue,
    output logic [15:0] diffuse_red,
    output logic [15:0] diffuse_green,
    output logic [15:0] diffuse_blue,
    output logic [15:0] specular_red,
    output logic [15:0] specular_green,
    output logic [15:0] specular_blue
);
    import phong_pkg::*;

    logic [47:0] light_reg;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Light intensity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg <= LIGHT_RESET;
        end
        else if (cfg_we)
        begin
            light_reg <= cfg_data;
        end
    end

    // Valid bits for the front stages
    logic [6:1] fv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            fv_reg <= {fv_reg[5:1], accept};
        end
    end

    // Stage 1: component products
    logic signed [31:0] s1_nl_reg  [3];
    logic        [31:0] s1_dd_reg  [3];
    logic        [31:0] s1_ikd_reg [3];
    logic        [31:0] s1_iks_reg [3];
    logic        [16:0] s1_amb_reg [3];
    logic signed [15:0] s1_d_reg   [3];
    logic signed [15:0] s1_n_reg   [3];
    logic signed [15:0] s1_l_reg   [3];
    logic        [7:0]  s1_shin_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_nl_reg[k]  <= $signed(surface_normal[16*k +: 16]) *
                             $signed(light_dir[16*k +: 16]);
            s1_dd_reg[k]  <= $signed(view_ray_dir[16*k +: 16]) *
                             $signed(view_ray_dir[16*k +: 16]);
            s1_ikd_reg[k] <= 32'(light_reg[16*k +: 16]) * 32'(diffuse_coef[16*k +: 16]);
            s1_iks_reg[k] <= 32'(light_reg[16*k +: 16]) * 32'(specular_coef[16*k +: 16]);
            s1_amb_reg[k] <= 17'(ambient_coef[16*k +: 16]) + 17'd5;
            s1_d_reg[k]   <= $signed(view_ray_dir[16*k +: 16]);
            s1_n_reg[k]   <= $signed(surface_normal[16*k +: 16]);
            s1_l_reg[k]   <= $signed(light_dir[16*k +: 16]);
        end
        s1_shin_reg <= shininess;
    end

    // Stage 2: dot products N.L and D.D, ambient divide by ten
    logic signed [33:0] s2_p_reg;
    logic        [33:0] s2_q_reg;
    logic        [15:0] s2_amb_reg [3];
    logic        [31:0] s2_ikd_reg [3];
    logic        [31:0] s2_iks_reg [3];
    logic signed [15:0] s2_d_reg   [3];
    logic signed [15:0] s2_n_reg   [3];
    logic signed [15:0] s2_l_reg   [3];
    logic        [7:0]  s2_shin_reg;

    always_ff @(posedge clk)
    begin
        s2_p_reg <= 34'(s1_nl_reg[0]) + 34'(s1_nl_reg[1]) + 34'(s1_nl_reg[2]);
        s2_q_reg <= 34'(s1_dd_reg[0]) + 34'(s1_dd_reg[1]) + 34'(s1_dd_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            s2_amb_reg[k] <= 16'((36'(s1_amb_reg[k]) * 36'(RECIP_TEN)) >> 22);
            s2_ikd_reg[k] <= s1_ikd_reg[k];
            s2_iks_reg[k] <= s1_iks_reg[k];
            s2_d_reg[k]   <= s1_d_reg[k];
            s2_n_reg[k]   <= s1_n_reg[k];
            s2_l_reg[k]   <= s1_l_reg[k];
        end
        s2_shin_reg <= s1_shin_reg;
    end

    // Stage 3: clamp N.L for diffuse, round it to Q13 for the reflection
    logic signed [34:0] s3_pr;
    logic        [26:0] s3_pc_next;
    logic        [26:0] s3_pc_reg;
    logic signed [20:0] s3_p13_reg;
    logic               s3_pos_reg;
    logic               s3_qnz_reg;
    logic        [31:0] s3_x_reg;
    logic        [15:0] s3_amb_reg [3];
    logic        [31:0] s3_ikd_reg [3];
    logic        [31:0] s3_iks_reg [3];
    logic signed [15:0] s3_d_reg   [3];
    logic signed [15:0] s3_n_reg   [3];
    logic signed [15:0] s3_l_reg   [3];
    logic        [7:0]  s3_shin_reg;

    always_comb
    begin
        s3_pr = 35'(s2_p_reg) + 35'sd4096;
        if (s2_p_reg <= 34'sd0)
        begin
            s3_pc_next = '0;
        end
        else if (s2_p_reg > 34'sd67108864)
        begin
            s3_pc_next = 27'd67108864;
        end
        else
        begin
            s3_pc_next = s2_p_reg[26:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s3_pc_reg   <= s3_pc_next;
        s3_p13_reg  <= 21'(s3_pr >>> 13);
        s3_pos_reg  <= (s2_p_reg > 34'sd0);
        s3_qnz_reg  <= (s2_q_reg != 34'd0);
        s3_x_reg    <= s2_q_reg[31:0];
        for (int k = 0; k < 3; k++)
        begin
            s3_amb_reg[k] <= s2_amb_reg[k];
            s3_ikd_reg[k] <= s2_ikd_reg[k];
            s3_iks_reg[k] <= s2_iks_reg[k];
            s3_d_reg[k]   <= s2_d_reg[k];
            s3_n_reg[k]   <= s2_n_reg[k];
            s3_l_reg[k]   <= s2_l_reg[k];
        end
        s3_shin_reg <= s2_shin_reg;
    end

    // Stage 4: p13 * N and I*Kd * clamped N.L
    logic signed [36:0] s4_m_reg    [3];
    logic        [58:0] s4_difp_reg [3];
    logic               s4_pos_reg;
    logic               s4_qnz_reg;
    logic        [31:0] s4_x_reg;
    logic        [15:0] s4_amb_reg  [3];
    logic        [31:0] s4_iks_reg  [3];
    logic signed [15:0] s4_d_reg    [3];
    logic signed [15:0] s4_l_reg    [3];
    logic        [7:0]  s4_shin_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s4_m_reg[k]    <= 37'(s3_p13_reg) * 37'(s3_n_reg[k]);
            s4_difp_reg[k] <= 59'(s3_ikd_reg[k]) * 59'(s3_pc_reg);
            s4_amb_reg[k]  <= s3_amb_reg[k];
            s4_iks_reg[k]  <= s3_iks_reg[k];
            s4_d_reg[k]    <= s3_d_reg[k];
            s4_l_reg[k]    <= s3_l_reg[k];
        end
        s4_pos_reg  <= s3_pos_reg;
        s4_qnz_reg  <= s3_qnz_reg;
        s4_x_reg    <= s3_x_reg;
        s4_shin_reg <= s3_shin_reg;
    end

    // Stage 5: reflection vector R, diffuse rounding and saturation
    logic signed [38:0] s5_r_reg   [3];
    logic        [15:0] s5_dif_reg [3];
    logic               s5_pos_reg;
    logic               s5_qnz_reg;
    logic        [31:0] s5_x_reg;
    logic        [15:0] s5_amb_reg [3];
    logic        [31:0] s5_iks_reg [3];
    logic signed [15:0] s5_d_reg   [3];
    logic        [7:0]  s5_shin_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s5_r_reg[k]   <= (39'(s4_m_reg[k]) <<< 1) - (39'(s4_l_reg[k]) <<< 13);
            s5_dif_reg[k] <= sat16(32'((s4_difp_reg[k] + 59'h20_0000_0000) >> 38));
            s5_amb_reg[k] <= s4_amb_reg[k];
            s5_iks_reg[k] <= s4_iks_reg[k];
            s5_d_reg[k]   <= s4_d_reg[k];
        end
        s5_pos_reg  <= s4_pos_reg;
        s5_qnz_reg  <= s4_qnz_reg;
        s5_x_reg    <= s4_x_reg;
        s5_shin_reg <= s4_shin_reg;
    end

    // Stage 6: D * R per component
    logic signed [54:0] s6_dr_reg  [3];
    logic        [15:0] s6_dif_reg [3];
    logic               s6_pos_reg;
    logic               s6_qnz_reg;
    logic        [31:0] s6_x_reg;
    logic        [15:0] s6_amb_reg [3];
    logic        [31:0] s6_iks_reg [3];
    logic        [7:0]  s6_shin_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s6_dr_reg[k]  <= 55'(s5_d_reg[k]) * 55'(s5_r_reg[k]);
            s6_dif_reg[k] <= s5_dif_reg[k];
            s6_amb_reg[k] <= s5_amb_reg[k];
            s6_iks_reg[k] <= s5_iks_reg[k];
        end
        s6_pos_reg  <= s5_pos_reg;
        s6_qnz_reg  <= s5_qnz_reg;
        s6_x_reg    <= s5_x_reg;
        s6_shin_reg <= s5_shin_reg;
    end

    // Stage 7: D.R sum, specular enable, square root entry
    logic signed [56:0] drs;
    logic signed [56:0] drs_neg;
    sq_t                sq_next0;
    sq_t                sq_reg   [0:SQRT_STEPS];
    logic               sq_vld_reg [0:SQRT_STEPS];

    always_comb
    begin
        drs     = 57'(s6_dr_reg[0]) + 57'(s6_dr_reg[1]) + 57'(s6_dr_reg[2]);
        drs_neg = -drs;
        sq_next0.side.spec_on = s6_qnz_reg & s6_pos_reg & (drs < 57'sd0);
        sq_next0.side.shin    = s6_shin_reg;
        for (int k = 0; k < 3; k++)
        begin
            sq_next0.side.amb[k] = s6_amb_reg[k];
            sq_next0.side.dif[k] = s6_dif_reg[k];
            sq_next0.side.iks[k] = s6_iks_reg[k];
        end
        sq_next0.x    = {s6_x_reg, 20'd0};
        sq_next0.rem  = '0;
        sq_next0.root = '0;
        sq_next0.s    = drs_neg[53:0];
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= sq_next0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else
        begin
            sq_vld_reg[0] <= fv_reg[6];
        end
    end

    // Square root of |D|^2 * 2^20, one root bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [29:0] rem2;
        logic [29:0] trial;
        sq_t         sq_next;

        always_comb
        begin
            rem2    = {sq_reg[j].rem[27:0], sq_reg[j].x[51:50]};
            trial   = {2'b00, sq_reg[j].root, 2'b01};
            sq_next = sq_reg[j];
            sq_next.x = {sq_reg[j].x[49:0], 2'b00};
            if (rem2 >= trial)
            begin
                sq_next.rem  = rem2 - trial;
                sq_next.root = {sq_reg[j].root[24:0], 1'b1};
            end
            else
            begin
                sq_next.rem  = rem2;
                sq_next.root = {sq_reg[j].root[24:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[j+1] <= sq_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end
    end

    // Divider entry: overflow check on the upper dividend bits
    dv_t  dv_next0;
    dv_t  dv_reg     [0:DIV_STEPS];
    logic dv_vld_reg [0:DIV_STEPS];

    always_comb
    begin
        dv_next0.side = sq_reg[SQRT_STEPS].side;
        dv_next0.t    = sq_reg[SQRT_STEPS].root;
        dv_next0.ovf  = (26'(sq_reg[SQRT_STEPS].s[53:32]) >= sq_reg[SQRT_STEPS].root);
        dv_next0.rem  = 26'(sq_reg[SQRT_STEPS].s[53:32]);
        dv_next0.sl   = sq_reg[SQRT_STEPS].s[31:0];
        dv_next0.quo  = '0;
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= dv_next0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else
        begin
            dv_vld_reg[0] <= sq_vld_reg[SQRT_STEPS];
        end
    end

    // Restoring division S / t, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [26:0] rem2;
        dv_t         dv_next;

        always_comb
        begin
            rem2       = {dv_reg[i].rem, dv_reg[i].sl[31]};
            dv_next    = dv_reg[i];
            dv_next.sl = {dv_reg[i].sl[30:0], 1'b0};
            if (rem2 >= {1'b0, dv_reg[i].t})
            begin
                dv_next.rem = 26'(rem2 - {1'b0, dv_reg[i].t});
                dv_next.quo = {dv_reg[i].quo[30:0], 1'b1};
            end
            else
            begin
                dv_next.rem = rem2[25:0];
                dv_next.quo = {dv_reg[i].quo[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[i+1] <= dv_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            end
        end
    end

    // Power entry: cap V.R, start the accumulator at one
    pw_t  pw_next0;
    pw_t  pw_reg     [0:POW_STEPS];
    logic pw_vld_reg [0:POW_STEPS];

    always_comb
    begin
        pw_next0.side = dv_reg[DIV_STEPS].side;
        if (dv_reg[DIV_STEPS].ovf || (dv_reg[DIV_STEPS].quo > POW_CAP))
        begin
            pw_next0.v = POW_CAP;
        end
        else
        begin
            pw_next0.v = dv_reg[DIV_STEPS].quo;
        end
        pw_next0.acc = ONE_Q16;
    end

    always_ff @(posedge clk)
    begin
        pw_reg[0] <= pw_next0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_vld_reg[0] <= 1'b0;
        end
        else
        begin
            pw_vld_reg[0] <= dv_vld_reg[DIV_STEPS];
        end
    end

    // Square-and-multiply from the top exponent bit, one multiply per stage
    for (genvar j = 0; j < POW_STEPS; j++)
    begin : g_pow
        localparam int EBIT = 7 - (j / 2);
        pw_t pw_next;

        always_comb
        begin
            pw_next = pw_reg[j];
            if ((j % 2) == 0)
            begin
                pw_next.acc = mul_q16(pw_reg[j].acc, pw_reg[j].acc);
            end
            else if (pw_reg[j].side.shin[EBIT])
            begin
                pw_next.acc = mul_q16(pw_reg[j].acc, pw_reg[j].v);
            end
        end

        always_ff @(posedge clk)
        begin
            pw_reg[j+1] <= pw_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pw_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                pw_vld_reg[j+1] <= pw_vld_reg[j];
            end
        end
    end

    // Final stage 1: I*Ks * power
    logic [63:0] f1_sp_reg [3];
    side_t       f1_side_reg;
    logic        f1_vld_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            f1_sp_reg[k] <= 64'(pw_reg[POW_STEPS].side.iks[k]) * 64'(pw_reg[POW_STEPS].acc);
        end
        f1_side_reg <= pw_reg[POW_STEPS].side;
    end

    // Final stage 2: specular rounding, saturation and gating; output word
    logic [63:0] spr [3];
    logic [15:0] spec_next [3];
    logic [15:0] spec_reg  [3];
    logic [15:0] amb_reg   [3];
    logic [15:0] dif_reg   [3];
    logic        done_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            spr[k] = (f1_sp_reg[k] + 64'd134217728) >> 28;
            if (!f1_side_reg.spec_on)
            begin
                spec_next[k] = '0;
            end
            else if (spr[k] > 64'd65535)
            begin
                spec_next[k] = 16'hFFFF;
            end
            else
            begin
                spec_next[k] = spr[k][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            spec_reg[k] <= spec_next[k];
            amb_reg[k]  <= f1_side_reg.amb[k];
            dif_reg[k]  <= f1_side_reg.dif[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= pw_vld_reg[POW_STEPS];
            done_reg   <= f1_vld_reg;
        end
    end

    assign done           = done_reg;
    assign ambient_red    = amb_reg[0];
    assign ambient_green  = amb_reg[1];
    assign ambient_blue   = amb_reg[2];
    assign diffuse_red    = dif_reg[0];
    assign diffuse_green  = dif_reg[1];
    assign diffuse_blue   = dif_reg[2];
    assign specular_red   = spec_reg[0];
    assign specular_green = spec_reg[1];
    assign specular_blue  = spec_reg[2];

endmodule

### test/tb.sv
// Self-checking testbench for phong_lighting_shader: directed table, then random samples.
// Depends on phong_pkg (LIGHT_RESET) and the RTL of phong_lighting_shader.
module tb;
    import phong_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 84;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1700;

    // one shading sample
    typedef struct packed {
        logic [47:0] ray;
        logic [47:0] nrm;
        logic [47:0] lgt;
        logic [47:0] ka;
        logic [47:0] kd;
        logic [47:0] ks;
        logic [7:0]  shin;
    } sample_t;

    // one shaded result
    typedef struct packed {
        logic [2:0][15:0] amb;
        logic [2:0][15:0] dif;
        logic [2:0][15:0] spc;
    } shade_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic [47:0] cfg_data = '0;
    logic [47:0] view_ray_dir = '0;
    logic [47:0] surface_normal = '0;
    logic [47:0] light_dir = '0;
    logic [47:0] ambient_coef = '0;
    logic [47:0] diffuse_coef = '0;
    logic [47:0] specular_coef = '0;
    logic [7:0]  shininess = '0;
    logic        done;
    logic [15:0] ambient_red, ambient_green, ambient_blue;
    logic [15:0] diffuse_red, diffuse_green, diffuse_blue;
    logic [15:0] specular_red, specular_green, specular_blue;

    always #5 clk = ~clk;

    phong_lighting_shader dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .view_ray_dir(view_ray_dir), .surface_normal(surface_normal),
        .light_dir(light_dir), .ambient_coef(ambient_coef),
        .diffuse_coef(diffuse_coef), .specular_coef(specular_coef),
        .shininess(shininess), .done(done),
        .ambient_red(ambient_red), .ambient_green(ambient_green),
        .ambient_blue(ambient_blue), .diffuse_red(diffuse_red),
        .diffuse_green(diffuse_green), .diffuse_blue(diffuse_blue),
        .specular_red(specular_red), .specular_green(specular_green),
        .specular_blue(specular_blue)
    );

    logic [47:0] light_model = LIGHT_RESET;
    shade_t      shade_queue[$];
    int          errors = 0;
    int          idle_cycles = 0;
    string       chan_name[3] = '{"red", "green", "blue"};

    function automatic logic signed [63:0] vec_comp(logic [47:0] w, int k);
        return 64'(signed'(w[16*k +: 16]));
    endfunction

    function automatic logic [63:0] sat_chan(logic [63:0] x);
        return (x > 64'd65535) ? 64'd65535 : x;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] q16_mul_cap(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = (a * b + 64'd32768) >> 16;
        return (r > 64'h8000_0000) ? 64'h8000_0000 : r;
    endfunction

    // expected shading of one sample under the current light
    function automatic shade_t shade_sample(sample_t s, logic [47:0] li);
        shade_t o;
        logic signed [63:0] d[3], n[3], l[3], r[3];
        logic signed [63:0] p, dr, p13, y;
        logic [63:0] q, pc, ik, v, acc;
        logic spec_on;
        p = 0; q = 0; dr = 0; acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = vec_comp(s.ray, k);
            n[k] = vec_comp(s.nrm, k);
            l[k] = vec_comp(s.lgt, k);
        end
        for (int k = 0; k < 3; k++)
        begin
            p += n[k] * l[k];
            q += 64'(d[k] * d[k]);
        end
        for (int k = 0; k < 3; k++)
            o.amb[k] = 16'((64'(s.ka[16*k +: 16]) + 5) / 10);
        pc = (p <= 0) ? 64'd0 : ((p > 64'sd67108864) ? 64'd67108864 : 64'(p));
        for (int k = 0; k < 3; k++)
        begin
            ik = 64'(li[16*k +: 16]) * 64'(s.kd[16*k +: 16]);
            o.dif[k] = 16'(sat_chan((ik * pc + (64'd1 << 37)) >> 38));
        end
        // round half up to Q13 (arithmetic shift floors)
        y = p + 64'sd4096;
        p13 = y >>> 13;
        for (int k = 0; k < 3; k++)
            r[k] = 2 * p13 * n[k] - l[k] * 64'sd8192;
        for (int k = 0; k < 3; k++)
            dr += d[k] * r[k];
        spec_on = (q != 0) && (p > 0) && (dr < 0);
        if (spec_on)
        begin
            v = 64'(-dr) / floor_sqrt(q << 20);
            if (v > 64'h8000_0000) v = 64'h8000_0000;
            acc = 64'd65536;
            for (int b = 7; b >= 0; b--)
            begin
                acc = q16_mul_cap(acc, acc);
                if (s.shin[b]) acc = q16_mul_cap(acc, v);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            ik = 64'(li[16*k +: 16]) * 64'(s.ks[16*k +: 16]);
            o.spc[k] = spec_on ? 16'(sat_chan((ik * acc + (64'd1 << 27)) >> 28)) : 16'd0;
        end
        return o;
    endfunction

    function automatic logic [15:0] rand_unit_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(0, 16384) - 8192);
        if (r == 7) return 16'($urandom);
        return (r == 8) ? 16'h8000 : 16'h7FFF;
    endfunction

    function automatic logic [47:0] rand_vec(bit wild);
        if (wild) return {16'($urandom), 16'($urandom), 16'($urandom)};
        return {rand_unit_comp(), rand_unit_comp(), rand_unit_comp()};
    endfunction

    function automatic logic [47:0] rand_colour();
        case ($urandom_range(0, 3))
            0: return {16'($urandom), 16'($urandom), 16'($urandom)};
            1: return {3{16'hFFFF}};
            default: return {16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                             16'($urandom_range(0, 4096))};
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        bit wild;
        wild = ($urandom_range(0, 7) == 0);
        s.ray = rand_vec(wild);
        s.nrm = rand_vec(wild);
        // often a light close to the normal, so specular is reached
        s.lgt = ($urandom_range(0, 2) == 0) ? s.nrm ^ 48'($urandom_range(0, 255)) : rand_vec(wild);
        if ($urandom_range(0, 2) == 0)
            s.ray = {16'(-signed'(s.lgt[47:32])), 16'(-signed'(s.lgt[31:16])),
                     16'(-signed'(s.lgt[15:0]))} ^ 48'($urandom_range(0, 255));
        s.ka = rand_colour();
        s.kd = rand_colour();
        s.ks = rand_colour();
        s.shin = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
        return s;
    endfunction

    // result check against oldest expectation
    always @(posedge clk)
    begin
        shade_t got, exp_s;
        if (rst_n && done)
        begin
            got.amb = {ambient_blue, ambient_green, ambient_red};
            got.dif = {diffuse_blue, diffuse_green, diffuse_red};
            got.spc = {specular_blue, specular_green, specular_red};
            if (shade_queue.size() == 0)
            begin
                $error("result word with no sample pending");
                errors++;
            end
            else
            begin
                exp_s = shade_queue.pop_front();
                for (int k = 0; k < 3; k++)
                begin
                    if (got.amb[k] !== exp_s.amb[k])
                    begin
                        $error("ambient_%s expected %h got %h", chan_name[k],
                               exp_s.amb[k], got.amb[k]);
                        errors++;
                    end
                    if (got.dif[k] !== exp_s.dif[k])
                    begin
                        $error("diffuse_%s expected %h got %h", chan_name[k],
                               exp_s.dif[k], got.dif[k]);
                        errors++;
                    end
                    if (got.spc[k] !== exp_s.spc[k])
                    begin
                        $error("specular_%s expected %h got %h", chan_name[k],
                               exp_s.spc[k], got.spc[k]);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // drive one sample, hold start until accepted
    task automatic send_sample(sample_t s, bit has_exp, shade_t exp_fixed);
        start          <= 1'b1;
        view_ray_dir   <= s.ray;
        surface_normal <= s.nrm;
        light_dir      <= s.lgt;
        ambient_coef   <= s.ka;
        diffuse_coef   <= s.kd;
        specular_coef  <= s.ks;
        shininess      <= s.shin;
        @(posedge clk);
        while (busy) @(posedge clk);
        shade_queue.push_back(has_exp ? exp_fixed : shade_sample(s, light_model));
    endtask

    task automatic sender_gap(bit allow);
        int n;
        if (allow && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (shade_queue.size() != 0) @(posedge clk);
        repeat (LATENCY / 4) @(posedge clk);
    endtask

    task automatic write_light(logic [47:0] val);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        light_model = val;
    endtask

    sample_t dir_table[12];
    bit      dir_fixed[12];
    shade_t  dir_exp[12];

    initial
    begin
        shade_t zero_shade;
        sample_t s;
        logic [47:0] lights[5];
        zero_shade = '0;

        // directed rows: ray, normal, light, ka, kd, ks, shininess
        // all zero: every term is zero
        dir_table[0] = '0; dir_fixed[0] = 1; dir_exp[0] = '0;
        // max coefficients, back-facing light: ambient 6554, rest zero
        dir_table[1] = {48'h0, 48'h0000_0000_2000, 48'h0000_0000_E000,
                        {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, 8'd255};
        dir_fixed[1] = 1;
        dir_exp[1] = zero_shade; dir_exp[1].amb = {3{16'd6554}};
        // zero-length ray with facing light: specular zero
        dir_table[2] = {48'h0, 48'h0000_0000_2000, 48'h0000_0000_2000,
                        48'h0, {3{16'h1000}}, {3{16'h1000}}, 8'd4};
        dir_fixed[2] = 1;
        dir_exp[2] = zero_shade; dir_exp[2].dif = {3{16'h1000}};
        // head-on view: V.R = 1, specular = Ks
        dir_table[3] = {48'h0000_0000_E000, 48'h0000_0000_2000, 48'h0000_0000_2000,
                        48'h0, 48'h0, {3{16'h1000}}, 8'd10};
        dir_fixed[3] = 1;
        dir_exp[3] = zero_shade; dir_exp[3].spc = {3{16'h1000}};
        // reflection away from view
        dir_table[4] = {48'h0000_0000_2000, 48'h0000_0000_2000, 48'h0000_0000_2000,
                        48'h0, 48'h0, {3{16'hFFFF}}, 8'd1};
        dir_fixed[4] = 1; dir_exp[4] = zero_shade;
        // shininess zero, oversized vectors, saturation
        dir_table[5] = {48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                        {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, 8'd0};
        dir_fixed[5] = 0;
        dir_table[6] = {48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                        {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, 8'd255};
        dir_fixed[6] = 0;
        dir_table[7] = {48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                        {3{16'h0001}}, {3{16'h0005}}, {3{16'h0004}}, 8'd128};
        dir_fixed[7] = 0;
        // large V.R saturating the specular output
        dir_table[8] = {48'h0000_0000_8001, 48'h0000_0000_7FFF, 48'h0000_0000_1000,
                        48'h0, 48'h0, {3{16'hFFFF}}, 8'd3};
        dir_fixed[8] = 0;
        // oblique vectors
        dir_table[9] = {48'h0000_1000_E000, 48'h0000_16A1_16A1, 48'h0000_0000_2000,
                        48'h0009_000A_000E, 48'h0800_1000_2000, 48'h1000_0800_0400, 8'd7};
        dir_fixed[9] = 0;
        dir_table[10] = {48'hE000_0000_0000, 48'h2000_0000_0000, 48'h1800_0000_1000,
                         48'h1234_5678_9ABC, 48'hFFFF_0000_8000, 48'h0001_FFFF_4000, 8'd85};
        dir_fixed[10] = 0;
        dir_table[11] = {48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA, 48'h5555_5555_AAAA,
                         48'hAAAA_AAAA_5555, 48'h5555_AAAA_AAAA, 48'hAAAA_5555_5555, 8'd170};
        dir_fixed[11] = 0;

        lights[0] = LIGHT_RESET;
        lights[1] = 48'h0;
        lights[2] = 48'hFFFF_FFFF_FFFF;
        lights[3] = 48'h0800_2000_1000;
        lights[4] = 48'($urandom) << 16 | 48'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset light
        for (int i = 0; i < 12; i++)
            send_sample(dir_table[i], dir_fixed[i], dir_exp[i]);
        drain();

        // random phases, one light setting each; last phase runs without gaps
        for (int ph = 0; ph < 6; ph++)
        begin
            write_light((ph < 5) ? lights[ph] : LIGHT_RESET);
            // extreme lights repeat a few directed rows
            if (ph == 1 || ph == 2)
                for (int i = 5; i < 12; i++)
                    send_sample(dir_table[i], 0, zero_shade);
            for (int i = 0; i < N_RANDOM / 6; i++)
            begin
                s = rand_sample();
                send_sample(s, 0, zero_shade);
                sender_gap(ph < 5 && (i % 200) > 30);
            end
            drain();
        end

        if (errors == 0 && shade_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
rtl/phong_pkg.sv
rtl/phong_lighting_shader.sv
test/tb.sv
